>>> rtl/core/point_to_segment_distance_core_defines.svh
// Assertion macros used by the core's top-level RTL file.
// Both forms are empty in synthesis builds.
`ifndef POINT_TO_SEGMENT_DISTANCE_CORE_DEFINES_SVH
`define POINT_TO_SEGMENT_DISTANCE_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define PSD_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");
`define PSD_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define PSD_ASSERT(lbl, clk, rst, prop)
`define PSD_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

>>> rtl/core/psd_pkg.sv
`timescale 1ns / 1ps
package psd_pkg;

  localparam int COORD_BITS  = 24;
  localparam int T_FRAC_BITS = 16;

  localparam int DIFF_BITS  = COORD_BITS + 1;
  localparam int PROD_BITS  = 2 * DIFF_BITS;
  localparam int DOT_BITS   = PROD_BITS + 1;
  localparam int LEN_BITS   = PROD_BITS - 1;
  localparam int REM_BITS   = LEN_BITS + 1;
  localparam int Q_BITS     = T_FRAC_BITS + 1;
  localparam int MAG_BITS   = COORD_BITS;
  localparam int SCALE_BITS = MAG_BITS + Q_BITS;
  localparam int OFF_BITS   = SCALE_BITS - T_FRAC_BITS;
  localparam int NEAR_BITS  = OFF_BITS + 1;
  localparam int DIST_BITS  = 50;

  localparam int IN_BITS       = 6 * COORD_BITS;
  localparam int OUT_USED_BITS = 2 * COORD_BITS + DIST_BITS + 2;
  localparam int OUT_BITS      = ((OUT_USED_BITS + 7) / 8) * 8;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [DIFF_BITS-1:0]  diff_t;

  typedef enum logic [1:0] {
    WHERE_WITHIN = 2'd0,
    WHERE_BEFORE = 2'd1,
    WHERE_PAST   = 2'd2
  } where_t;

  // word handed from one divider cell to the next
  typedef struct packed {
    logic [REM_BITS-1:0] rem;
    logic [LEN_BITS-1:0] len2;
    logic [Q_BITS-1:0]   quo;
    where_t              where;
    diff_t               dx;
    diff_t               dy;
    coord_t              sx;
    coord_t              sy;
    coord_t              px;
    coord_t              py;
  } div_t;

endpackage

>>> rtl/core/psd_front.sv
`timescale 1ns / 1ps
module psd_front
  import psd_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   in_valid,
  input  coord_t point_x,
  input  coord_t point_y,
  input  coord_t start_x,
  input  coord_t start_y,
  input  coord_t end_x,
  input  coord_t end_y,
  output logic   up_ready,
  output logic   out_valid,
  output div_t   out_data,
  input  logic   dn_ready
);

  logic v1, v2, v3, v4;
  logic en1, en2, en3, en4;

  diff_t  s1_dx, s1_dy, s1_ox, s1_oy;
  coord_t s1_sx, s1_sy, s1_px, s1_py;

  logic signed [PROD_BITS-1:0] s2_dotx, s2_doty, s2_lenx, s2_leny;
  diff_t  s2_dx, s2_dy;
  coord_t s2_sx, s2_sy, s2_px, s2_py;

  logic signed [DOT_BITS-1:0] s3_dot;
  logic [LEN_BITS-1:0]        s3_len2;
  diff_t  s3_dx, s3_dy;
  coord_t s3_sx, s3_sy, s3_px, s3_py;

  logic [PROD_BITS-1:0] len_sum;
  where_t               where_c;
  logic [REM_BITS-1:0]  rem_c;

  assign en4      = !v4 || dn_ready;
  assign en3      = !v3 || en4;
  assign en2      = !v2 || en3;
  assign en1      = !v1 || en2;
  assign up_ready = en1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (en1) v1 <= in_valid;
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
      if (en4) v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      s1_dx <= DIFF_BITS'(end_x) - DIFF_BITS'(start_x);
      s1_dy <= DIFF_BITS'(end_y) - DIFF_BITS'(start_y);
      s1_ox <= DIFF_BITS'(point_x) - DIFF_BITS'(start_x);
      s1_oy <= DIFF_BITS'(point_y) - DIFF_BITS'(start_y);
      s1_sx <= start_x;
      s1_sy <= start_y;
      s1_px <= point_x;
      s1_py <= point_y;
    end
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      s2_dotx <= s1_dx * s1_ox;
      s2_doty <= s1_dy * s1_oy;
      s2_lenx <= s1_dx * s1_dx;
      s2_leny <= s1_dy * s1_dy;
      s2_dx   <= s1_dx;
      s2_dy   <= s1_dy;
      s2_sx   <= s1_sx;
      s2_sy   <= s1_sy;
      s2_px   <= s1_px;
      s2_py   <= s1_py;
    end
  end

  // squares are non-negative and each below 2^48
  assign len_sum = PROD_BITS'($unsigned(s2_lenx) + $unsigned(s2_leny));

  always_ff @(posedge clk) begin
    if (en3) begin
      s3_dot  <= DOT_BITS'(s2_dotx) + DOT_BITS'(s2_doty);
      s3_len2 <= len_sum[LEN_BITS-1:0];
      s3_dx   <= s2_dx;
      s3_dy   <= s2_dy;
      s3_sx   <= s2_sx;
      s3_sy   <= s2_sy;
      s3_px   <= s2_px;
      s3_py   <= s2_py;
    end
  end

  // clamp outside [0, len2]; the divider remainder starts at the dot product, or zero if clamped
  always_comb begin
    if (s3_dot < 0) begin
      where_c = WHERE_BEFORE;
    end else if (s3_dot > $signed({2'b00, s3_len2})) begin
      where_c = WHERE_PAST;
    end else begin
      where_c = WHERE_WITHIN;
    end
    rem_c = (where_c == WHERE_WITHIN) ? s3_dot[REM_BITS-1:0] : '0;
  end

  always_ff @(posedge clk) begin
    if (en4) begin
      out_data.rem   <= rem_c;
      out_data.len2  <= s3_len2;
      out_data.quo   <= '0;
      out_data.where <= where_c;
      out_data.dx    <= s3_dx;
      out_data.dy    <= s3_dy;
      out_data.sx    <= s3_sx;
      out_data.sy    <= s3_sy;
      out_data.px    <= s3_px;
      out_data.py    <= s3_py;
    end
  end

  assign out_valid = v4;

endmodule

>>> rtl/core/psd_cell.sv
`timescale 1ns / 1ps
module psd_cell
  import psd_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  input  div_t in_data,
  output logic up_ready,
  output logic out_valid,
  output div_t out_data,
  input  logic dn_ready
);

  logic                en;
  logic                fits;
  logic [REM_BITS-1:0] diff;
  div_t                nxt;

  assign en       = !out_valid || dn_ready;
  assign up_ready = en;

  // one restoring step: compare, subtract, shift the remainder left
  always_comb begin
    fits = in_data.rem >= {1'b0, in_data.len2};
    diff = fits ? in_data.rem - {1'b0, in_data.len2} : in_data.rem;
    nxt      = in_data;
    nxt.rem  = {diff[REM_BITS-2:0], 1'b0};
    nxt.quo  = {in_data.quo[Q_BITS-2:0], fits};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data <= nxt;
    end
  end

endmodule

>>> rtl/core/psd_back.sv
`timescale 1ns / 1ps
module psd_back
  import psd_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  div_t                 in_data,
  output logic                 up_ready,
  output logic                 out_valid,
  output coord_t               near_x,
  output coord_t               near_y,
  output logic [DIST_BITS-1:0] dist_squared,
  output where_t               where_on,
  input  logic                 dn_ready
);

  logic ve, vf, vg, vh;
  logic ene, enf, eng, enh, eni;

  logic [Q_BITS-1:0]    t_sel;
  logic [DIFF_BITS-1:0] magx_full, magy_full;

  logic [SCALE_BITS-1:0] e_prodx, e_prody;
  logic                  e_negx, e_negy;
  coord_t                e_sx, e_sy, e_px, e_py;
  where_t                e_where;

  logic [SCALE_BITS-1:0] rndx, rndy;
  logic [OFF_BITS-1:0]   offx, offy;
  logic signed [NEAR_BITS-1:0] nearx_w, neary_w;

  coord_t f_nx, f_ny, f_px, f_py;
  where_t f_where;

  diff_t  g_ddx, g_ddy;
  coord_t g_nx, g_ny;
  where_t g_where;

  logic signed [PROD_BITS-1:0] h_sqx, h_sqy;
  coord_t h_nx, h_ny;
  where_t h_where;

  assign eni      = !out_valid || dn_ready;
  assign enh      = !vh || eni;
  assign eng      = !vg || enh;
  assign enf      = !vf || eng;
  assign ene      = !ve || enf;
  assign up_ready = ene;

  always_ff @(posedge clk) begin
    if (rst) begin
      ve        <= 1'b0;
      vf        <= 1'b0;
      vg        <= 1'b0;
      vh        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (ene) ve <= in_valid;
      if (enf) vf <= ve;
      if (eng) vg <= vf;
      if (enh) vh <= vg;
      if (eni) out_valid <= vh;
    end
  end

  always_comb begin
    if (in_data.where == WHERE_BEFORE) begin
      t_sel = '0;
    end else if (in_data.where == WHERE_PAST) begin
      t_sel = Q_BITS'(1) << T_FRAC_BITS;
    end else begin
      t_sel = in_data.quo;
    end
    magx_full = in_data.dx[DIFF_BITS-1] ? DIFF_BITS'(-in_data.dx) : DIFF_BITS'(in_data.dx);
    magy_full = in_data.dy[DIFF_BITS-1] ? DIFF_BITS'(-in_data.dy) : DIFF_BITS'(in_data.dy);
  end

  always_ff @(posedge clk) begin
    if (ene) begin
      e_prodx <= SCALE_BITS'(magx_full[MAG_BITS-1:0]) * SCALE_BITS'(t_sel);
      e_prody <= SCALE_BITS'(magy_full[MAG_BITS-1:0]) * SCALE_BITS'(t_sel);
      e_negx  <= in_data.dx[DIFF_BITS-1];
      e_negy  <= in_data.dy[DIFF_BITS-1];
      e_sx    <= in_data.sx;
      e_sy    <= in_data.sy;
      e_px    <= in_data.px;
      e_py    <= in_data.py;
      e_where <= in_data.where;
    end
  end

  // round the magnitude half away from zero, then apply the sign
  always_comb begin
    rndx    = e_prodx + (SCALE_BITS'(1) << (T_FRAC_BITS - 1));
    rndy    = e_prody + (SCALE_BITS'(1) << (T_FRAC_BITS - 1));
    offx    = rndx[SCALE_BITS-1:T_FRAC_BITS];
    offy    = rndy[SCALE_BITS-1:T_FRAC_BITS];
    nearx_w = NEAR_BITS'(e_sx) + (e_negx ? -$signed({1'b0, offx}) : $signed({1'b0, offx}));
    neary_w = NEAR_BITS'(e_sy) + (e_negy ? -$signed({1'b0, offy}) : $signed({1'b0, offy}));
  end

  always_ff @(posedge clk) begin
    if (enf) begin
      f_nx    <= nearx_w[COORD_BITS-1:0];
      f_ny    <= neary_w[COORD_BITS-1:0];
      f_px    <= e_px;
      f_py    <= e_py;
      f_where <= e_where;
    end
  end

  always_ff @(posedge clk) begin
    if (eng) begin
      g_ddx   <= DIFF_BITS'(f_nx) - DIFF_BITS'(f_px);
      g_ddy   <= DIFF_BITS'(f_ny) - DIFF_BITS'(f_py);
      g_nx    <= f_nx;
      g_ny    <= f_ny;
      g_where <= f_where;
    end
  end

  always_ff @(posedge clk) begin
    if (enh) begin
      h_sqx   <= g_ddx * g_ddx;
      h_sqy   <= g_ddy * g_ddy;
      h_nx    <= g_nx;
      h_ny    <= g_ny;
      h_where <= g_where;
    end
  end

  // output register: holds while the receiver stalls
  always_ff @(posedge clk) begin
    if (eni) begin
      dist_squared <= DIST_BITS'($unsigned(h_sqx) + $unsigned(h_sqy));
      near_x       <= h_nx;
      near_y       <= h_ny;
      where_on     <= h_where;
    end
  end

endmodule

>>> rtl/core/point_to_segment_distance_core.sv
`timescale 1ns / 1ps
// Point to segment distance, squared, on a signed 24-bit grid.
// Input stream s_axis carries one query word: a point and the two endpoints
// of a segment. Output stream m_axis returns one word per query: the closest
// point on the segment, the squared distance to it and where the projection
// fell (within, clamped before the start, clamped past the end).
// Pipeline: four front stages (offsets, products, dot and squared length,
// clamp), one divider cell per quotient bit (17 cells of a restoring
// divider), and five back stages (scale, round, difference, square, sum into
// the output reg).
// Throughput: one word per cycle unless m_axis_tready stalls; each cell takes
// one quotient bit and passes its word on every cycle it is not stalled.
// Reset clears every valid bit; the block is empty and ready after reset.
// When the receiver stalls, the output register holds its word and the
// stages behind it keep filling bubbles; s_axis_tready drops only when every
// stage holds a word.
`include "point_to_segment_distance_core_defines.svh"
module point_to_segment_distance_core
  import psd_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // point_x, point_y, start_x, start_y, end_x, end_y
  input  logic [IN_BITS-1:0]  s_axis_tdata,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // near_x, near_y, dist_squared, where_on, zero pad
  output logic [OUT_BITS-1:0] m_axis_tdata
);

  div_t cd [0:Q_BITS];
  logic cv [0:Q_BITS];
  logic cr [0:Q_BITS];

  coord_t               near_x, near_y;
  logic [DIST_BITS-1:0] dist_squared;
  where_t               where_on;

  psd_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .point_x   (coord_t'(s_axis_tdata[COORD_BITS-1:0])),
    .point_y   (coord_t'(s_axis_tdata[2*COORD_BITS-1:COORD_BITS])),
    .start_x   (coord_t'(s_axis_tdata[3*COORD_BITS-1:2*COORD_BITS])),
    .start_y   (coord_t'(s_axis_tdata[4*COORD_BITS-1:3*COORD_BITS])),
    .end_x     (coord_t'(s_axis_tdata[5*COORD_BITS-1:4*COORD_BITS])),
    .end_y     (coord_t'(s_axis_tdata[6*COORD_BITS-1:5*COORD_BITS])),
    .up_ready  (s_axis_tready),
    .out_valid (cv[0]),
    .out_data  (cd[0]),
    .dn_ready  (cr[0])
  );

  for (genvar i = 0; i < Q_BITS; i++) begin : g_cell
    psd_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (cv[i]),
      .in_data   (cd[i]),
      .up_ready  (cr[i]),
      .out_valid (cv[i+1]),
      .out_data  (cd[i+1]),
      .dn_ready  (cr[i+1])
    );
  end

  psd_back u_back (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (cv[Q_BITS]),
    .in_data      (cd[Q_BITS]),
    .up_ready     (cr[Q_BITS]),
    .out_valid    (m_axis_tvalid),
    .near_x       (near_x),
    .near_y       (near_y),
    .dist_squared (dist_squared),
    .where_on     (where_on),
    .dn_ready     (m_axis_tready)
  );

  assign m_axis_tdata = {{(OUT_BITS - OUT_USED_BITS){1'b0}}, where_on, dist_squared,
                         near_y, near_x};

  // an empty output register lets every stage advance
  `PSD_ASSERT(a_ready_when_empty, clk, rst, !m_axis_tvalid |-> s_axis_tready)
  `PSD_ASSERT(a_ready_when_taken, clk, rst, m_axis_tready |-> s_axis_tready)
  // a stalled front word stays in place for the first cell
  `PSD_ASSERT_NEXT(a_front_hold, clk, rst, cv[0] && !cr[0], cv[0])
  // an unclamped quotient never exceeds one
  `PSD_ASSERT(a_quo_range, clk, rst,
    (cv[Q_BITS] && cd[Q_BITS].where == WHERE_WITHIN && cd[Q_BITS].len2 != 0) |->
    (cd[Q_BITS].quo <= (Q_BITS'(1) << T_FRAC_BITS)))

endmodule
